### hw/rtl/pcbo_pkg.sv
// ---------------------------------------------------------------------------
// pcbo_pkg: shared types and constants
// Sizes, command codes, register indexes, channel payloads and the
// controller/datapath command group for the priority-commanded output unit.
// ---------------------------------------------------------------------------
package pcbo_pkg;

  localparam int NUM_OUTPUTS    = 4;
  localparam int NUM_PRIORITIES = 16;
  localparam int MASK_W         = 4;
  localparam int TIME_W         = 32;
  localparam int INST_W         = 8;
  localparam int PRIO_W         = 5;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 32;

  localparam int OUT_IDX_W  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int PRIO_IDX_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int MASK_IDX_W = $clog2(MASK_W);

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_RELINQUISH = 2'd1,
    CMD_READ       = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RELINQ_DEFAULT = 2'd0,
    CFG_OUT_OF_SERVICE = 2'd1,
    CFG_MIN_ON_TIME    = 2'd2,
    CFG_MIN_OFF_TIME   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [INST_W-1:0] instance_req;
    logic [PRIO_W-1:0] priority_req;
    logic              value;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic level;
    logic change_flag;
    logic slot_value;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the item and the addressed output's record
    logic commit;  // resolve, write back and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic                  found;
    logic [PRIO_IDX_W-1:0] idx;
  } first_slot_t;

  // Lowest-numbered active slot (highest priority)
  function automatic first_slot_t find_first(input logic [NUM_PRIORITIES-1:0] act);
    first_slot_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (act[i]) begin
        r.found = 1'b1;
        r.idx   = PRIO_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/pcbo_in_if.sv
// ---------------------------------------------------------------------------
// pcbo_in_if: command channel
// Valid/ready channel that carries one command item.
// ---------------------------------------------------------------------------
interface pcbo_in_if;
  import pcbo_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/pcbo_out_if.sv
// ---------------------------------------------------------------------------
// pcbo_out_if: result channel
// Valid/ready channel that carries one result item.
// ---------------------------------------------------------------------------
interface pcbo_out_if;
  import pcbo_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/pcbo_ctrl.sv
// ---------------------------------------------------------------------------
// pcbo_ctrl: sequencing controller
// Two-state machine: capture an item, then commit it once the result
// register is free or draining. Owns the input ready and result valid flag.
// ---------------------------------------------------------------------------
module pcbo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pcbo_pkg::dp_cmd_t dp_cmd
);
  import pcbo_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   can_commit;

  assign can_commit = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (can_commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    dp_cmd         = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        dp_cmd.load = in_valid;
      end
      ST_EVAL: begin
        if (can_commit) begin
          dp_cmd.commit  = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/pcbo_datapath.sv
// ---------------------------------------------------------------------------
// pcbo_datapath: output records and resolution logic
// Holds the priority arrays, present values, change times and flags, the
// configuration registers and the result register.
// ---------------------------------------------------------------------------
module pcbo_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pcbo_pkg::dp_cmd_t               dp_cmd,
  input  pcbo_pkg::in_item_t              in_item,
  output pcbo_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [pcbo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcbo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcbo_pkg::*;

  // Configuration
  logic [MASK_W-1:0] relinq_default_mask;
  logic [MASK_W-1:0] oos_mask;
  logic [TIME_W-1:0] min_on_time;
  logic [TIME_W-1:0] min_off_time;

  // Output records
  logic [NUM_PRIORITIES-1:0] act_rows   [NUM_OUTPUTS];
  logic [NUM_PRIORITIES-1:0] val_rows   [NUM_OUTPUTS];
  logic                      out_levels     [NUM_OUTPUTS];
  logic [TIME_W-1:0]         change_time    [NUM_OUTPUTS];
  logic                      change_flags   [NUM_OUTPUTS];

  // Captured item
  cmd_t                      cmd_q;
  logic                      inst_ok_q;
  logic                      pvalid_q;
  logic [OUT_IDX_W-1:0]      o_q;
  logic [PRIO_IDX_W-1:0]     p_q;
  logic                      val_q;
  logic [TIME_W-1:0]         now_q;
  logic [NUM_PRIORITIES-1:0] act_row_q;
  logic [NUM_PRIORITIES-1:0] val_row_q;
  logic                      pv_q;
  logic                      flag_q;
  logic [TIME_W-1:0]         held_q;
  logic                      dflt_q;
  logic                      oos_q;

  // Capture-side decode
  logic                      inst_ok;
  logic                      pvalid;
  logic [OUT_IDX_W-1:0]      o_idx;
  logic [PRIO_IDX_W-1:0]     p_idx;
  logic                      in_mask;
  logic [MASK_IDX_W-1:0]     mask_idx;
  logic [NUM_PRIORITIES-1:0] act_mod;
  logic [NUM_PRIORITIES-1:0] val_mod;

  // Commit-side resolution
  first_slot_t               winner;
  logic                      win_val;
  logic                      hold;
  logic                      eval_en;
  logic                      pv_new;
  logic                      changed;
  logic                      flag_new;
  logic                      ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      relinq_default_mask <= '0;
      oos_mask            <= '0;
      min_on_time         <= '0;
      min_off_time        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RELINQ_DEFAULT: relinq_default_mask <= cfg_data[MASK_W-1:0];
        CFG_OUT_OF_SERVICE: oos_mask            <= cfg_data[MASK_W-1:0];
        CFG_MIN_ON_TIME:    min_on_time         <= cfg_data[TIME_W-1:0];
        CFG_MIN_OFF_TIME:   min_off_time        <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign inst_ok  = in_item.instance_req < INST_W'(NUM_OUTPUTS);
  assign pvalid   = (in_item.priority_req != '0) &&
                    (in_item.priority_req <= PRIO_W'(NUM_PRIORITIES));
  assign o_idx    = in_item.instance_req[OUT_IDX_W-1:0];
  assign p_idx    = PRIO_IDX_W'(in_item.priority_req - PRIO_W'(1));
  assign in_mask  = in_item.instance_req < INST_W'(MASK_W);
  assign mask_idx = in_item.instance_req[MASK_IDX_W-1:0];

  // Apply the slot update on the way into the capture registers
  always_comb begin
    act_mod = act_rows[o_idx];
    val_mod = val_rows[o_idx];
    if (inst_ok && pvalid) begin
      case (in_item.cmd)
        CMD_WRITE: begin
          act_mod[p_idx] = 1'b1;
          val_mod[p_idx] = in_item.value;
        end
        CMD_RELINQUISH: act_mod[p_idx] = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q     <= in_item.cmd;
      inst_ok_q <= inst_ok;
      pvalid_q  <= pvalid;
      o_q       <= o_idx;
      p_q       <= p_idx;
      val_q     <= in_item.value;
      now_q     <= in_item.now_ms;
      act_row_q <= act_mod;
      val_row_q <= val_mod;
      pv_q      <= out_levels[o_idx];
      flag_q    <= change_flags[o_idx];
      held_q    <= in_item.now_ms - change_time[o_idx];
      dflt_q    <= in_mask && relinq_default_mask[mask_idx];
      oos_q     <= in_mask && oos_mask[mask_idx];
    end
  end

  assign winner  = find_first(act_row_q);
  assign win_val = val_row_q[winner.idx];
  assign hold    = (pv_q && !win_val && (held_q < min_on_time)) ||
                   (!pv_q && win_val && (held_q < min_off_time));
  assign eval_en = inst_ok_q && pvalid_q &&
                   ((cmd_q == CMD_WRITE) || (cmd_q == CMD_RELINQUISH));

  always_comb begin
    pv_new = pv_q;
    ok     = 1'b0;
    case (cmd_q)
      CMD_WRITE: begin
        if (pvalid_q) begin
          ok = 1'b1;
          if (!winner.found) pv_new = dflt_q;
          else if (!hold)    pv_new = win_val;
        end else if (oos_q) begin
          ok     = 1'b1;
          pv_new = val_q;
        end
      end
      CMD_RELINQUISH: begin
        if (pvalid_q) begin
          ok = 1'b1;
          if (!winner.found) pv_new = dflt_q;
          else if (!hold)    pv_new = win_val;
        end
      end
      CMD_READ:  ok = 1'b1;
      CMD_CLEAR: ok = 1'b1;
      default: ;
    endcase
  end

  assign changed  = pv_new != pv_q;
  assign flag_new = (cmd_q == CMD_CLEAR) ? 1'b0 : (flag_q || changed);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        act_rows[i]     <= '0;
        val_rows[i]     <= '0;
        out_levels[i]   <= 1'b0;
        change_time[i]  <= '0;
        change_flags[i] <= 1'b0;
      end
    end else if (dp_cmd.commit && inst_ok_q) begin
      if (eval_en) begin
        act_rows[o_q] <= act_row_q;
        val_rows[o_q] <= val_row_q;
      end
      out_levels[o_q]   <= pv_new;
      change_flags[o_q] <= flag_new;
      if (changed) change_time[o_q] <= now_q;
    end
  end

  // Result register; an invalid output reports all zero
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_item.ok          <= inst_ok_q && ok;
      out_item.level       <= inst_ok_q && pv_new;
      out_item.change_flag <= inst_ok_q && flag_new;
      out_item.slot_value  <= inst_ok_q && pvalid_q && act_row_q[p_q] && val_row_q[p_q];
    end
  end

endmodule

### hw/rtl/priority_commanded_binary_output_unit.sv
// ---------------------------------------------------------------------------
// priority_commanded_binary_output_unit: priority-commanded binary outputs
// Several binary outputs, each with a command priority array, minimum
// on/off hold times, relinquish defaults and out-of-service direct writes.
// ---------------------------------------------------------------------------
// rsp.valid is registered and rises with the commit in the resolve state,
//   which follows the capture state in which the command is taken.
// A new command is taken only once the read-modify-write of the
//   addressed output's record is done (capture state, then resolve-and-write state).
// A stalled result keeps the next command in its resolve state until taken.
// Reset (rst, synchronous) clears all records, configuration registers and
//   the sequencer.
// ---------------------------------------------------------------------------
module priority_commanded_binary_output_unit (
  input  logic                             clk,
  input  logic                             rst,
  pcbo_in_if.sink                          req,
  pcbo_out_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [pcbo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcbo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcbo_pkg::*;

  // Command group from the sequencer to the datapath
  dp_cmd_t dp_cmd;

  // Sequencer: accept a transaction in idle, commit once the result
  // register is free or draining this cycle.
  pcbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  // Datapath: capture the item together with the output's updated priority
  // row and elapsed time, then pick the winner, apply the hold check and
  // write the record back.
  pcbo_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .in_item   (req.item),
    .out_item  (rsp.item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### tb/sv/tb_priority_commanded_binary_output_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_commanded_binary_output_unit: self-checking testbench
// Sends write, relinquish, read and clear commands to the unit and checks
// every result against an in-bench prediction of the priority arrays, hold
// times, relinquish defaults and out-of-service writes, under several
// register settings and random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_priority_commanded_binary_output_unit;
  import pcbo_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;
  localparam int SETTLE_CYC  = 4;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pcbo_in_if  req_ch ();
  pcbo_out_if rsp_ch ();

  priority_commanded_binary_output_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // -------------------------------------------------------------------------
  // Shadow copy of the unit: priority arrays, output records, registers
  // -------------------------------------------------------------------------
  bit                slot_val    [NUM_OUTPUTS][NUM_PRIORITIES];
  bit                slot_on     [NUM_OUTPUTS][NUM_PRIORITIES];
  bit                out_level   [NUM_OUTPUTS];
  logic [TIME_W-1:0] out_stamp   [NUM_OUTPUTS];
  bit                out_changed [NUM_OUTPUTS];

  logic [MASK_W-1:0] dflt_mask  = '0;
  logic [MASK_W-1:0] oos_mask   = '0;
  logic [TIME_W-1:0] min_on_ms  = '0;
  logic [TIME_W-1:0] min_off_ms = '0;

  // Commands waiting for the driver, results waiting for the unit
  in_item_t  cmd_q[$];
  out_item_t result_q[$];

  bit in_fire;
  int cycles        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int holds_seen    = 0;
  int direct_writes = 0;
  int rejected      = 0;
  int settings_run  = 0;
  int gap_left      = 0;
  int burst_left    = 1;
  int rx_mode       = 0;
  int rx_left       = 0;
  int rx_tick       = 0;
  logic [TIME_W-1:0] clock_ms;

  // Switch an output's present value; a real change stamps time and flags it
  function automatic void drive_level(int o, bit v, logic [TIME_W-1:0] now);
    if (out_level[o] != v) begin
      out_level[o]   = v;
      out_stamp[o]   = now;
      out_changed[o] = 1'b1;
    end
  endfunction

  // Pick the winning slot and apply the minimum on/off hold times
  function automatic void settle_output(int o, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held;
    int                win;
    bit                target;
    win = -1;
    for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
      if (slot_on[o][p]) win = p;
    end
    if (win < 0) begin
      // nothing commanded: the default takes over with no hold
      target = (o < MASK_W) ? dflt_mask[o] : 1'b0;
    end else begin
      target = slot_val[o][win];
      held   = now - out_stamp[o];
      if ((out_level[o] && !target && held < min_on_ms) ||
          (!out_level[o] && target && held < min_off_ms)) begin
        holds_seen++;
        return;
      end
    end
    drive_level(o, target, now);
  endfunction

  // Apply one command to the shadow copy and return the result it must give
  function automatic out_item_t resolve_command(in_item_t it);
    out_item_t r;
    bit        pok;
    int        o;
    int        p;
    r = '0;
    if (it.instance_req >= NUM_OUTPUTS) begin
      rejected++;
      return r;
    end
    o   = int'(it.instance_req);
    pok = (it.priority_req >= 1) && (it.priority_req <= NUM_PRIORITIES);
    p   = pok ? int'(it.priority_req) - 1 : 0;
    case (it.cmd)
      CMD_WRITE: begin
        if (pok) begin
          slot_val[o][p] = it.value;
          slot_on[o][p]  = 1'b1;
          settle_output(o, it.now_ms);
          r.ok = 1'b1;
        end else if (o < MASK_W && oos_mask[o]) begin
          drive_level(o, it.value, it.now_ms);
          direct_writes++;
          r.ok = 1'b1;
        end
      end
      CMD_RELINQUISH: begin
        if (pok) begin
          slot_on[o][p] = 1'b0;
          settle_output(o, it.now_ms);
          r.ok = 1'b1;
        end
      end
      CMD_READ: r.ok = 1'b1;
      CMD_CLEAR: begin
        out_changed[o] = 1'b0;
        r.ok = 1'b1;
      end
    endcase
    if (!r.ok) rejected++;
    r.level       = out_level[o];
    r.change_flag = out_changed[o];
    r.slot_value  = pok && slot_on[o][p] && slot_val[o][p];
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: sample at the rising edge, check results, predict accepted commands
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    in_fire = !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, result_q.size());
        $display("tb_priority_commanded_binary_output_unit NOT OK");
        $finish;
      end else begin
        // check first: a result never belongs to a command taken at this edge
        if (rsp_ch.valid && rsp_ch.ready) begin
          got = rsp_ch.item;
          results_seen++;
          if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("unexpected result %0d: ok=%0b pv=%0b chg=%0b slot=%0b",
                       results_seen, got.ok, got.level, got.change_flag,
                       got.slot_value);
          end else begin
            want = result_q.pop_front();
            if (got.ok != want.ok || got.level != want.level ||
                got.change_flag != want.change_flag ||
                got.slot_value != want.slot_value) begin
              mismatches++;
              if (mismatches <= SHOW_LIMIT)
                $display({"mismatch on result %0d: expected ok=%0b pv=%0b chg=%0b ",
                          "slot=%0b, got ok=%0b pv=%0b chg=%0b slot=%0b"},
                         results_seen, want.ok, want.level, want.change_flag,
                         want.slot_value, got.ok, got.level, got.change_flag,
                         got.slot_value);
            end
          end
        end
        if (in_fire) begin
          result_q.push_back(resolve_command(req_ch.item));
          items_sent++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver: present commands at the falling edge in bursts with random gaps
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !in_fire) begin
      // hold the offered transaction until it is taken
    end else begin
      if (in_fire) void'(cmd_q.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.item  <= cmd_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // a zero gap lets two bursts run back to back
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: ready follows a mode that is drawn anew at random, after a random run of cycles
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0:       rsp_ch.ready <= 1'b1;                          // never stall
        1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);   // coin toss
        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: rsp_ch.ready <= (rx_tick % 7 == 0);            // long fixed stalls
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic queue_cmd(cmd_t c, int inst, int prio, bit v, logic [TIME_W-1:0] now);
    in_item_t it;
    it.cmd          = c;
    it.instance_req = INST_W'(inst);
    it.priority_req = PRIO_W'(prio);
    it.value        = v;
    it.now_ms       = now;
    cmd_q.push_back(it);
  endtask

  // Write a register while the unit is idle and mirror it in the shadow copy
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_RELINQ_DEFAULT: dflt_mask  = data[MASK_W-1:0];
      CFG_OUT_OF_SERVICE: oos_mask   = data[MASK_W-1:0];
      CFG_MIN_ON_TIME:    min_on_ms  = data[TIME_W-1:0];
      CFG_MIN_OFF_TIME:   min_off_ms = data[TIME_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] dflt, logic [31:0] oos, logic [31:0] on_ms,
                          logic [31:0] off_ms);
    write_reg(CFG_RELINQ_DEFAULT, dflt);
    write_reg(CFG_OUT_OF_SERVICE, oos);
    write_reg(CFG_MIN_ON_TIME, on_ms);
    write_reg(CFG_MIN_OFF_TIME, off_ms);
    settings_run++;
  endtask

  // Wait until every command is taken and every result has come back
  task automatic drain();
    while (cmd_q.size() != 0 || req_ch.valid || result_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Mostly legal commands on real outputs with time moving forward; the rest
  // are bad priorities on real outputs and plain noise
  task automatic queue_random(int n, int step_max);
    int   pick;
    int   sel;
    cmd_t c;
    @(posedge clk);
    for (int k = 0; k < n; k++) begin
      pick     = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, step_max);
      if (pick < 10) begin
        queue_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 31), 1'($urandom_range(0, 1)), $urandom());
      end else begin
        sel = $urandom_range(0, 99);
        c   = (sel < 45) ? CMD_WRITE : (sel < 75) ? CMD_RELINQUISH :
              (sel < 90) ? CMD_READ : CMD_CLEAR;
        if (pick < 17)
          queue_cmd(c, $urandom_range(0, NUM_OUTPUTS - 1),
                    ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(NUM_PRIORITIES + 1, 31),
                    1'($urandom_range(0, 1)), clock_ms);
        else
          queue_cmd(c, $urandom_range(0, NUM_OUTPUTS - 1),
                    $urandom_range(1, NUM_PRIORITIES), 1'($urandom_range(0, 1)), clock_ms);
      end
    end
  endtask

  task automatic run_phase(logic [31:0] dflt, logic [31:0] oos, logic [31:0] on_ms,
                           logic [31:0] off_ms, int n, int step_max,
                           logic [TIME_W-1:0] start_ms);
    set_regs(dflt, oos, on_ms, off_ms);
    clock_ms = start_ms;
    queue_random(n, step_max);
    drain();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.item  = '0;
    rsp_ch.ready = 1'b0;
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      out_level[o]   = 1'b0;
      out_stamp[o]   = '0;
      out_changed[o] = 1'b0;
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
        slot_val[o][p] = 1'b0;
        slot_on[o][p]  = 1'b0;
      end
    end
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: bad outputs, bad priorities, priority order, defaults
    @(posedge clk);
    queue_cmd(CMD_READ,       255, 31, 1'b1, 32'hFFFF_FFFF);  // bad output, all zero
    queue_cmd(CMD_WRITE,        4,  1, 1'b1, 32'd0);          // first bad output
    queue_cmd(CMD_WRITE,        0,  0, 1'b1, 32'd0);          // bad priority, in service
    queue_cmd(CMD_RELINQUISH,   0, 17, 1'b0, 32'd0);          // bad priority relinquish
    queue_cmd(CMD_READ,         3,  0, 1'b0, 32'd0);          // read ignores priority
    queue_cmd(CMD_WRITE,        0, 16, 1'b1, 32'd0);          // lowest priority drives 1
    queue_cmd(CMD_CLEAR,        0, 31, 1'b0, 32'd5);
    queue_cmd(CMD_WRITE,        0,  1, 1'b0, 32'd10);         // highest priority wins
    queue_cmd(CMD_RELINQUISH,   0,  1, 1'b0, 32'd20);         // falls back to slot 16
    queue_cmd(CMD_RELINQUISH,   0, 16, 1'b0, 32'd30);         // empty array: default
    drain();

    // Hold times, out-of-service direct writes, immediate default, time wrap
    set_regs(32'h0000_000A, 32'h0000_0005, 32'd100, 32'd50);
    @(posedge clk);
    queue_cmd(CMD_WRITE,        2,  0, 1'b1, 32'd1000);       // direct write, no hold
    queue_cmd(CMD_WRITE,        2, 31, 1'b0, 32'd1001);       // direct write back to 0
    queue_cmd(CMD_WRITE,        1,  5, 1'b1, 32'd2000);       // off long enough: on
    queue_cmd(CMD_WRITE,        1,  3, 1'b0, 32'd2050);       // min on time not met
    queue_cmd(CMD_RELINQUISH,   1,  3, 1'b0, 32'd2099);
    queue_cmd(CMD_WRITE,        1,  3, 1'b0, 32'd2100);       // exactly min on time
    queue_cmd(CMD_RELINQUISH,   1,  3, 1'b0, 32'd2101);       // slot 5 held back
    queue_cmd(CMD_RELINQUISH,   1,  5, 1'b0, 32'd2102);       // default 1 at once
    queue_cmd(CMD_WRITE,        3,  2, 1'b1, 32'hFFFF_FFF0);
    queue_cmd(CMD_WRITE,        3,  1, 1'b0, 32'h0000_0050);  // wrapped, 96 ms held
    queue_cmd(CMD_WRITE,        3,  1, 1'b0, 32'h0000_0054);  // wrapped, 100 ms held
    drain();

    // Random phases, extremes of every register among them
    run_phase(32'hFFFF_FFF5, $urandom(), 32'd60, 32'd30, 140, 25, 32'd0);
    run_phase(32'd0, 32'h0000_000F, 32'd0, 32'd0, 120, 1000, $urandom());
    run_phase(32'h0000_000F, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 100,
              32'hFFFF_FF80);
    run_phase($urandom(), $urandom(), 32'hFFFF_FFFF, 32'd0, 120, 50, $urandom());
    run_phase($urandom(), $urandom(), $urandom_range(0, 300), $urandom_range(0, 300),
              200, 40, 32'hFFFF_FE00);
    run_phase($urandom(), $urandom(), $urandom_range(0, 150), $urandom_range(0, 150),
              120, 20, $urandom());

    repeat (SETTLE_CYC * 4) @(negedge clk);
    $display("covered %0d commands under %0d register settings, %0d results checked",
             items_sent, settings_run, results_seen);
    $display("saw %0d held-back switches, %0d direct writes, %0d rejected commands",
             holds_seen, direct_writes, rejected);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb_priority_commanded_binary_output_unit OK");
    end else begin
      $display("%0d mismatches, %0d results never came", mismatches, result_q.size());
      $display("tb_priority_commanded_binary_output_unit NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pcbo_pkg.sv
hw/rtl/pcbo_in_if.sv
hw/rtl/pcbo_out_if.sv
hw/rtl/pcbo_ctrl.sv
hw/rtl/pcbo_datapath.sv
hw/rtl/priority_commanded_binary_output_unit.sv
tb/sv/tb_priority_commanded_binary_output_unit.sv
